[design/indexed_array_table_macros.svh]
// Assertion macros shared by the checker of the indexed array table.
// No dependencies; include by bare file name.
`ifndef INDEXED_ARRAY_TABLE_MACROS_SVH
`define INDEXED_ARRAY_TABLE_MACROS_SVH

// Checked outside reset only.
`define IAT_CHECK(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("indexed_array_table check failed");

// Checked at every edge, reset included.
`define IAT_CHECK_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("indexed_array_table reset check failed");

`endif

[design/iat_pkg.sv]
// Package of the indexed array table: command and status codes, cell control type.
// No dependencies.
package iat_pkg;

   localparam int unsigned VALUE_W = 32;

   localparam logic [2:0] CMD_APPEND = 3'd0;
   localparam logic [2:0] CMD_REMOVE = 3'd1;
   localparam logic [2:0] CMD_INSERT = 3'd2;
   localparam logic [2:0] CMD_ERASE  = 3'd3;
   localparam logic [2:0] CMD_SEARCH = 3'd4;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_EMPTY    = 3'd2;
   localparam logic [2:0] ST_BADPOS   = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   // Broadcast to every cell in the cycle a command beat is taken.
   typedef struct packed {
      logic                      go;      // beat accepted
      logic                      commit;  // edit passes its checks
      logic [2:0]                command;
      logic signed [VALUE_W-1:0] value;
   } iat_ctl_type;

endpackage

[design/iat_cell.sv]
// One entry of the table: holds a value, shifts from either neighbour, registers a match.
// Depends on iat_pkg.
module iat_cell #(
   parameter int unsigned INDEX = 0,
   parameter int unsigned CW    = 7
) (
   input  logic                              clock,
   input  iat_pkg::iat_ctl_type              ctl,
   input  logic [CW-1:0]                     pos,
   input  logic [CW-1:0]                     count,
   input  logic signed [iat_pkg::VALUE_W-1:0] left_data,
   input  logic signed [iat_pkg::VALUE_W-1:0] right_data,
   output logic signed [iat_pkg::VALUE_W-1:0] data,
   output logic                              match
);

   localparam logic [CW-1:0] IDX = CW'(INDEX);

   logic signed [iat_pkg::VALUE_W-1:0] data_ff, data_in;
   logic                               match_ff, match_in;

   always_comb begin
      data_in  = data_ff;
      match_in = match_ff;
      if (ctl.go && (ctl.command == iat_pkg::CMD_SEARCH)) begin
         match_in = (data_ff == ctl.value);
      end
      if (ctl.commit) begin
         case (ctl.command)
            iat_pkg::CMD_APPEND: begin
               if (IDX == count) data_in = ctl.value;
            end
            iat_pkg::CMD_INSERT: begin
               if (IDX == pos) begin
                  data_in = ctl.value;
               end else if ((IDX > pos) && (IDX <= count)) begin
                  data_in = left_data;
               end
            end
            iat_pkg::CMD_ERASE: begin
               if ((IDX >= pos) && ((IDX + CW'(1)) < count)) data_in = right_data;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

   assign data  = data_ff;
   assign match = match_ff;

endmodule

[design/indexed_array_table.sv]
// Indexed array table top level: command decode, entry count, search scan, result beat.
// Depends on iat_pkg and iat_cell.
//
// Usage:
//   req_ channel carries one command beat (command, position, value); rsp_ channel
//   returns one beat per command (status, found_index, entry_count).
//   Append, remove last, insert at and erase at finish in the accept cycle: all
//   cells shift or load in parallel and the result beat is valid the next cycle.
//   Undefined command codes behave the same way and change nothing.
//   Search registers a match flag in every cell at accept, then a scan pointer
//   walks the flags one entry a cycle and stops at the first hit or at
//   entry_count; the result beat follows. The scan is what sets search
//   throughput; edits sustain one beat per cycle while rsp_ready stays high.
//   req_ready is high while no scan runs and the result register is empty or
//   being drained in the same cycle, so a stalled receiver holds back new beats
//   and the held result stays unchanged.
//   Reset clears the entry count, the scan state and the result valid; entry
//   contents are not cleared and are only read below the count.
module indexed_array_table #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [2:0]                         req_command,
   input  logic [6:0]                         req_position,
   input  logic signed [iat_pkg::VALUE_W-1:0] req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [2:0]                         rsp_status,
   output logic [5:0]                         rsp_found_index,
   output logic [6:0]                         rsp_entry_count
);

   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned IDX_W = $clog2(CAPACITY);
   localparam int unsigned CW    = (CNT_W > 7) ? CNT_W : 7;

   localparam logic [0:0] S_IDLE = 1'b0;
   localparam logic [0:0] S_SCAN = 1'b1;

   logic [0:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic [5:0]       rsp_found_ff, rsp_found_in;
   logic [6:0]       rsp_count_ff, rsp_count_in;

   logic                 accept;
   logic                 full;
   logic                 empty;
   logic [CW-1:0]        pos_w;
   logic [CW-1:0]        count_w;
   logic [2:0]           edit_status;
   logic [CNT_W-1:0]     edit_count;
   logic                 scan_end;
   logic                 scan_hit;
   iat_pkg::iat_ctl_type ctl;

   logic signed [iat_pkg::VALUE_W-1:0] cell_data [CAPACITY];
   logic [CAPACITY-1:0]                match_vec;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign pos_w     = CW'(req_position);
   assign count_w   = CW'(count_ff);

   always_comb begin
      edit_status = iat_pkg::ST_OK;
      edit_count  = count_ff;
      unique case (req_command)
         iat_pkg::CMD_APPEND: begin
            if (full) edit_status = iat_pkg::ST_FULL;
            else      edit_count  = count_ff + CNT_W'(1);
         end
         iat_pkg::CMD_REMOVE: begin
            if (empty) edit_status = iat_pkg::ST_EMPTY;
            else       edit_count  = count_ff - CNT_W'(1);
         end
         iat_pkg::CMD_INSERT: begin
            if (pos_w > count_w) edit_status = iat_pkg::ST_BADPOS;
            else if (full)       edit_status = iat_pkg::ST_FULL;
            else                 edit_count  = count_ff + CNT_W'(1);
         end
         iat_pkg::CMD_ERASE: begin
            if (empty)                 edit_status = iat_pkg::ST_EMPTY;
            else if (pos_w >= count_w) edit_status = iat_pkg::ST_BADPOS;
            else                       edit_count  = count_ff - CNT_W'(1);
         end
         default: ;
      endcase
   end

   always_comb begin
      ctl.go      = accept;
      ctl.commit  = accept && (edit_status == iat_pkg::ST_OK)
                    && (req_command != iat_pkg::CMD_SEARCH);
      ctl.command = req_command;
      ctl.value   = req_value;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [iat_pkg::VALUE_W-1:0] left_data;
      logic signed [iat_pkg::VALUE_W-1:0] right_data;
      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_left
         assign left_data = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_right
         assign right_data = cell_data[i+1];
      end
      iat_cell #(
         .INDEX (i),
         .CW    (CW)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .pos        (pos_w),
         .count      (count_w),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i]),
         .match      (match_vec[i])
      );
   end

   assign scan_end = (scan_ff >= count_ff);
   assign scan_hit = !scan_end && match_vec[scan_ff[IDX_W-1:0]];

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_command == iat_pkg::CMD_SEARCH) begin
                  state_in = S_SCAN;
                  scan_in  = '0;
               end else begin
                  count_in      = edit_count;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = edit_status;
                  rsp_found_in  = '0;
                  rsp_count_in  = 7'(edit_count);
               end
            end
         end
         S_SCAN: begin
            if (scan_end || scan_hit) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = scan_hit ? iat_pkg::ST_OK : iat_pkg::ST_NOTFOUND;
               rsp_found_in  = scan_hit ? 6'(scan_ff[IDX_W-1:0]) : '0;
               rsp_count_in  = 7'(count_ff);
            end else begin
               scan_in = scan_ff + CNT_W'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_found_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

[design/iat_checker.sv]
// Port-level checker for the indexed array table, bound to the top level.
// Depends on iat_pkg and indexed_array_table_macros.svh.
`include "indexed_array_table_macros.svh"

module iat_checker #(
   parameter int unsigned CAPACITY = 64
) (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic [5:0] rsp_found_index,
   input logic [6:0] rsp_entry_count
);

   localparam logic [6:0] CAP_SHOWN = 7'(CAPACITY);

   // no result beat straight out of reset
   `IAT_CHECK_ALWAYS(a_reset_quiet, reset |=> !rsp_valid)

   // full is only reported with the table at capacity
   `IAT_CHECK(a_full_count, (rsp_valid && (rsp_status == iat_pkg::ST_FULL))
      |-> (rsp_entry_count == CAP_SHOWN))

   // empty is only reported with no entries
   `IAT_CHECK(a_empty_count, (rsp_valid && (rsp_status == iat_pkg::ST_EMPTY))
      |-> (rsp_entry_count == 7'd0))

   // a failed command never carries an index
   `IAT_CHECK(a_index_on_ok, (rsp_valid && (rsp_status != iat_pkg::ST_OK))
      |-> (rsp_found_index == 6'd0))

   // a held result beat blocks new requests
   `IAT_CHECK(a_stall_blocks_req, (rsp_valid && !rsp_ready) |-> !req_ready)

endmodule

bind indexed_array_table iat_checker #(.CAPACITY(CAPACITY)) u_iat_checker (.*);

[verif/indexed_array_table_tb.sv]
// Self-checking testbench for indexed_array_table: directed table walk, then random commands.
// Depends on iat_pkg and the indexed_array_table RTL; results checked against a local model.
module indexed_array_table_tb;

   localparam int unsigned TABLE_DEPTH   = 64;
   localparam int          RANDOM_CMDS   = 1900;
   localparam int          CYCLE_LIMIT   = 1000000;
   localparam int          SETTLE_CYCLES = TABLE_DEPTH + 16;
   localparam int          LONG_HOLD     = 300;
   localparam int          HOLD_BEAT_A   = 400;
   localparam int          HOLD_BEAT_B   = 1300;

   localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

   localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

   typedef struct {
      logic [2:0] status;
      logic [5:0] found_index;
      logic [6:0] entry_count;
   } table_result_type;

   typedef struct {
      logic [2:0]         command;
      logic [6:0]         position;
      logic signed [31:0] value;
      int                 reps;
      bit                 typed;
      table_result_type   result;
   } table_row_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [2:0]          req_command;
   logic [6:0]          req_position;
   logic signed [31:0]  req_value;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [2:0]          rsp_status;
   logic [5:0]          rsp_found_index;
   logic [6:0]          rsp_entry_count;

   // Shadow copy of the table contents and count
   logic signed [31:0]  shadow_entries [TABLE_DEPTH];
   int unsigned         shadow_count;

   table_result_type    pending_results [$];
   table_row_type       directed_rows [$];
   int                  mismatch_count = 0;
   int                  cycle_count = 0;
   int                  sent_count = 0;
   int                  search_hits = 0;
   int                  status_tally [5];

   indexed_array_table #(
      .CAPACITY(TABLE_DEPTH)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_found_index(rsp_found_index),
      .rsp_entry_count(rsp_entry_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("run exceeded %0d cycles", CYCLE_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic table_result_type apply_table_cmd(input logic [2:0] cmd,
                                                        input logic [6:0] pos,
                                                        input logic signed [31:0] val);
      table_result_type res;
      int               i;
      bit               hit;
      res.status      = iat_pkg::ST_OK;
      res.found_index = '0;
      hit             = 1'b0;
      case (cmd)
         iat_pkg::CMD_APPEND: begin
            if (shadow_count >= TABLE_DEPTH) begin
               res.status = iat_pkg::ST_FULL;
            end else begin
               shadow_entries[6'(shadow_count)] = val;
               shadow_count++;
            end
         end
         iat_pkg::CMD_REMOVE: begin
            if (shadow_count == 0) res.status = iat_pkg::ST_EMPTY;
            else shadow_count--;
         end
         iat_pkg::CMD_INSERT: begin
            if (pos > shadow_count) begin
               res.status = iat_pkg::ST_BADPOS;
            end else if (shadow_count >= TABLE_DEPTH) begin
               res.status = iat_pkg::ST_FULL;
            end else begin
               for (i = shadow_count; i > pos; i--)
                  shadow_entries[6'(i)] = shadow_entries[6'(i - 1)];
               shadow_entries[6'(pos)] = val;
               shadow_count++;
            end
         end
         iat_pkg::CMD_ERASE: begin
            if (shadow_count == 0) begin
               res.status = iat_pkg::ST_EMPTY;
            end else if (pos >= shadow_count) begin
               res.status = iat_pkg::ST_BADPOS;
            end else begin
               for (i = pos + 1; i < shadow_count; i++)
                  shadow_entries[6'(i - 1)] = shadow_entries[6'(i)];
               shadow_count--;
            end
         end
         iat_pkg::CMD_SEARCH: begin
            res.status = iat_pkg::ST_NOTFOUND;
            for (i = 0; i < shadow_count && !hit; i++) begin
               if (shadow_entries[6'(i)] == val) begin
                  hit             = 1'b1;
                  res.status      = iat_pkg::ST_OK;
                  res.found_index = i[5:0];
               end
            end
         end
         default: ;
      endcase
      res.entry_count = shadow_count[6:0];
      return res;
   endfunction

   task automatic add_row(input logic [2:0] cmd, input logic [6:0] pos,
                          input logic signed [31:0] val, input int reps, input bit typed,
                          input logic [2:0] st, input logic [5:0] idx, input logic [6:0] cnt);
      table_row_type row;
      row.command            = cmd;
      row.position           = pos;
      row.value              = val;
      row.reps               = reps;
      row.typed              = typed;
      row.result.status      = st;
      row.result.found_index = idx;
      row.result.entry_count = cnt;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // One request beat: random gap, offer, hold until taken, then record the expectation
   task automatic send_cmd(input logic [2:0] cmd, input logic [6:0] pos,
                           input logic signed [31:0] val, input bit typed,
                           input table_result_type typed_result);
      int               gap;
      table_result_type predicted;
      gap = ((sent_count / 100) % 5 == 4) ? 0 : $urandom_range(0, 10);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_position <= pos;
      req_value    <= val;
      do @(posedge clock); while (!req_ready);
      predicted = apply_table_cmd(cmd, pos, val);
      if (predicted.status <= iat_pkg::ST_NOTFOUND) status_tally[predicted.status]++;
      if (cmd == iat_pkg::CMD_SEARCH && predicted.status == iat_pkg::ST_OK) search_hits++;
      pending_results.insert(pending_results.size(), typed ? typed_result : predicted);
      sent_count++;
   endtask

   task automatic drain_results();
      int               stall;
      int               beats;
      table_result_type exp;
      beats = 0;
      forever begin
         if (beats == HOLD_BEAT_A || beats == HOLD_BEAT_B) stall = LONG_HOLD;
         else if ((beats / 100) % 5 == 2) stall = 0;
         else stall = $urandom_range(0, 10);
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         beats++;
         if (pending_results.size() == 0) begin
            $error("result beat with nothing expected");
            mismatch_count++;
         end else begin
            exp = pending_results.pop_front();
            if (rsp_status !== exp.status) begin
               $error("status: expected %0d, actual %0d", exp.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_found_index !== exp.found_index) begin
               $error("found_index: expected %0d, actual %0d", exp.found_index,
                      rsp_found_index);
               mismatch_count++;
            end
            if (rsp_entry_count !== exp.entry_count) begin
               $error("entry_count: expected %0d, actual %0d", exp.entry_count,
                      rsp_entry_count);
               mismatch_count++;
            end
         end
      end
   endtask

   function automatic logic signed [31:0] pick_value(input bit prefer_stored);
      int r;
      r = $urandom_range(0, 99);
      if (shadow_count > 0 && (prefer_stored ? r < 60 : r < 20))
         return shadow_entries[6'($urandom_range(0, shadow_count - 1))];
      r = $urandom_range(0, 99);
      if (r < 35) return $signed($urandom_range(0, 7)) - 4;
      if (r < 50) begin
         case ($urandom_range(0, 3))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return 32'sd0;
            default: return -32'sd1;
         endcase
      end
      return $signed($urandom);
   endfunction

   task automatic random_cmd(input int mode);
      int                 r;
      int                 t_app, t_ins, t_srch, t_rem, t_era;
      logic [2:0]         cmd;
      logic [6:0]         pos;
      logic signed [31:0] val;
      table_result_type   none;
      none = '{default: '0};
      case (mode)
         0:       begin t_app = 45; t_ins = 65; t_srch = 80; t_rem = 88; t_era = 97; end
         1:       begin t_app = 20; t_ins = 40; t_srch = 65; t_rem = 80; t_era = 95; end
         default: begin t_app = 10; t_ins = 20; t_srch = 40; t_rem = 70; t_era = 97; end
      endcase
      r   = $urandom_range(0, 99);
      pos = 7'($urandom_range(0, 127));
      if (r < t_app) cmd = iat_pkg::CMD_APPEND;
      else if (r < t_ins) cmd = iat_pkg::CMD_INSERT;
      else if (r < t_srch) cmd = iat_pkg::CMD_SEARCH;
      else if (r < t_rem) cmd = iat_pkg::CMD_REMOVE;
      else if (r < t_era) cmd = iat_pkg::CMD_ERASE;
      else cmd = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
      if (cmd == iat_pkg::CMD_INSERT && $urandom_range(0, 9) != 0)
         pos = 7'($urandom_range(0, shadow_count));
      if (cmd == iat_pkg::CMD_ERASE && shadow_count > 0 && $urandom_range(0, 9) != 0)
         pos = 7'($urandom_range(0, shadow_count - 1));
      val = pick_value(cmd == iat_pkg::CMD_SEARCH);
      send_cmd(cmd, pos, val, 1'b0, none);
   endtask

   initial begin
      table_row_type row;
      int            n;
      int            k;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_command  = iat_pkg::CMD_APPEND;
      req_position = '0;
      req_value    = '0;
      rsp_ready    = 1'b0;
      shadow_count = 0;
      foreach (status_tally[i]) status_tally[i] = 0;

      // Empty table corners, then extremes, out of range positions and a full table
      add_row(iat_pkg::CMD_SEARCH, 7'd0, 32'sd0, 1, 1'b1, iat_pkg::ST_NOTFOUND, 6'd0, 7'd0);
      add_row(iat_pkg::CMD_REMOVE, 7'd0, 32'sd0, 1, 1'b1, iat_pkg::ST_EMPTY, 6'd0, 7'd0);
      add_row(iat_pkg::CMD_ERASE, 7'd0, 32'sd0, 1, 1'b1, iat_pkg::ST_EMPTY, 6'd0, 7'd0);
      add_row(iat_pkg::CMD_INSERT, 7'd1, 32'sd5, 1, 1'b1, iat_pkg::ST_BADPOS, 6'd0, 7'd0);
      add_row(CMD_UNUSED_FIRST, 7'd0, 32'sd9, 1, 1'b1, iat_pkg::ST_OK, 6'd0, 7'd0);
      add_row(CMD_UNUSED_LAST, 7'd127, VAL_MAX, 1, 1'b1, iat_pkg::ST_OK, 6'd0, 7'd0);
      add_row(iat_pkg::CMD_APPEND, 7'd0, VAL_MAX, 1, 1'b1, iat_pkg::ST_OK, 6'd0, 7'd1);
      add_row(iat_pkg::CMD_APPEND, 7'd0, VAL_MIN, 1, 1'b1, iat_pkg::ST_OK, 6'd0, 7'd2);
      add_row(iat_pkg::CMD_INSERT, 7'd0, -32'sd1, 1, 1'b1, iat_pkg::ST_OK, 6'd0, 7'd3);
      add_row(iat_pkg::CMD_INSERT, 7'd3, 32'sd0, 1, 1'b1, iat_pkg::ST_OK, 6'd0, 7'd4);
      add_row(iat_pkg::CMD_SEARCH, 7'd0, VAL_MIN, 1, 1'b0, iat_pkg::ST_OK, 6'd0, 7'd0);
      add_row(iat_pkg::CMD_SEARCH, 7'd0, -32'sd1, 1, 1'b0, iat_pkg::ST_OK, 6'd0, 7'd0);
      add_row(iat_pkg::CMD_ERASE, 7'd4, 32'sd0, 1, 1'b1, iat_pkg::ST_BADPOS, 6'd0, 7'd4);
      add_row(iat_pkg::CMD_ERASE, 7'd127, 32'sd0, 1, 1'b1, iat_pkg::ST_BADPOS, 6'd0, 7'd4);
      add_row(iat_pkg::CMD_INSERT, 7'd127, 32'sd3, 1, 1'b1, iat_pkg::ST_BADPOS, 6'd0, 7'd4);
      add_row(iat_pkg::CMD_ERASE, 7'd0, 32'sd0, 1, 1'b1, iat_pkg::ST_OK, 6'd0, 7'd3);
      add_row(iat_pkg::CMD_SEARCH, 7'd0, 32'sd0, 1, 1'b0, iat_pkg::ST_OK, 6'd0, 7'd0);
      add_row(iat_pkg::CMD_REMOVE, 7'd0, 32'sd0, 1, 1'b1, iat_pkg::ST_OK, 6'd0, 7'd2);
      add_row(CMD_UNUSED_LAST, 7'd0, 32'sd0, 1, 1'b1, iat_pkg::ST_OK, 6'd0, 7'd2);
      add_row(iat_pkg::CMD_APPEND, 7'd0, 32'sd100, TABLE_DEPTH - 2, 1'b0, iat_pkg::ST_OK,
              6'd0, 7'd0);
      add_row(iat_pkg::CMD_APPEND, 7'd0, 32'sd7, 1, 1'b1, iat_pkg::ST_FULL, 6'd0, 7'd64);
      add_row(iat_pkg::CMD_INSERT, 7'd64, 32'sd7, 1, 1'b1, iat_pkg::ST_FULL, 6'd0, 7'd64);
      add_row(iat_pkg::CMD_INSERT, 7'd65, 32'sd7, 1, 1'b1, iat_pkg::ST_BADPOS, 6'd0, 7'd64);
      add_row(iat_pkg::CMD_SEARCH, 7'd0, 32'sd161, 1, 1'b0, iat_pkg::ST_OK, 6'd0, 7'd0);
      add_row(iat_pkg::CMD_ERASE, 7'd63, 32'sd0, 1, 1'b1, iat_pkg::ST_OK, 6'd0, 7'd63);
      add_row(iat_pkg::CMD_SEARCH, 7'd0, 32'sd12345, 1, 1'b0, iat_pkg::ST_OK, 6'd0, 7'd0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      fork
         drain_results();
      join_none

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         for (k = 0; k < row.reps; k++)
            send_cmd(row.command, row.position, row.value + k, row.typed, row.result);
      end

      for (n = 0; n < RANDOM_CMDS; n++) random_cmd((n / 150) % 3);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d commands, %0d searches found; statuses ok %0d, full %0d, empty %0d,",
               sent_count, search_hits, status_tally[iat_pkg::ST_OK],
               status_tally[iat_pkg::ST_FULL], status_tally[iat_pkg::ST_EMPTY]);
      $display("bad position %0d, not found %0d; %0d field mismatches",
               status_tally[iat_pkg::ST_BADPOS], status_tally[iat_pkg::ST_NOTFOUND],
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
